/* rtl/ps2kt_pkg.sv */
// Shared package for the PS/2 scan code key tracker.
// Holds the operation codes, scan code constants, the character lookup and
// the FIFO status type. Depends on nothing.
package ps2kt_pkg;

  // Operation codes carried on the op field.
  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  localparam logic [7:0] SCAN_RELEASE  = 8'hF0;
  localparam logic [7:0] SCAN_EXTENDED = 8'hE0;
  localparam logic [7:0] CHAR_ENTER    = 8'h0D;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] TABLE_SIZE    = 8'd94;

  localparam int MAP_ROWS   = 8;
  localparam int ROW_WIDTH  = 32;
  localparam int ROW_ADDR_W = 3;
  localparam int BIT_ADDR_W = 5;

  // Status that the key FIFO reports to the top level.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // Maps a completed scan code to its character.
  function automatic logic [7:0] char_lookup(input logic [7:0] code, input logic extended);
    logic [7:0] c;
    c = CHAR_NEWLINE;
    if (extended || (code >= TABLE_SIZE)) begin
      c = CHAR_ENTER;
    end else begin
      case (code)
        8'd14: c = 8'h60;
        8'd21: c = 8'h51;
        8'd22: c = 8'h31;
        8'd26: c = 8'h5A;
        8'd27: c = 8'h53;
        8'd28: c = 8'h41;
        8'd29: c = 8'h57;
        8'd30: c = 8'h32;
        8'd33: c = 8'h43;
        8'd34: c = 8'h58;
        8'd35: c = 8'h44;
        8'd36: c = 8'h45;
        8'd37: c = 8'h34;
        8'd38: c = 8'h33;
        8'd41: c = 8'h20;
        8'd42: c = 8'h56;
        8'd43: c = 8'h46;
        8'd44: c = 8'h54;
        8'd45: c = 8'h52;
        8'd46: c = 8'h35;
        8'd49: c = 8'h4E;
        8'd50: c = 8'h42;
        8'd51: c = 8'h48;
        8'd52: c = 8'h47;
        8'd53: c = 8'h59;
        8'd54: c = 8'h36;
        8'd58: c = 8'h4D;
        8'd59: c = 8'h4A;
        8'd60: c = 8'h55;
        8'd61: c = 8'h37;
        8'd62: c = 8'h38;
        8'd65: c = 8'h2C;
        8'd66: c = 8'h4B;
        8'd67: c = 8'h49;
        8'd68: c = 8'h4F;
        8'd69: c = 8'h30;
        8'd70: c = 8'h39;
        8'd73: c = 8'h2E;
        8'd74: c = 8'h2F;
        8'd75: c = 8'h4C;
        8'd76: c = 8'h3B;
        8'd77: c = 8'h50;
        8'd78: c = 8'h2D;
        8'd82: c = 8'h27;
        8'd84: c = 8'h5B;
        8'd85: c = 8'h3D;
        8'd91: c = 8'h5D;
        8'd93: c = 8'h5C;
        default: c = CHAR_NEWLINE;
      endcase
    end
    return c;
  endfunction

endpackage

/* rtl/ps2kt_key_fifo.sv */
// Key character FIFO for the PS/2 scan code key tracker.
// A synchronous memory with registered read data and wrapping pointers.
// Depends on ps2kt_pkg for the status type.
module ps2kt_key_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push_req,
  input  logic [7:0]               push_data,
  input  logic                     pop_req,
  output logic [7:0]               pop_data,
  output ps2kt_pkg::fifo_status_t  status
);
  import ps2kt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // A push into a full FIFO and a pop from an empty one are dropped.
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign do_push      = push_req && !status.full;
  assign do_pop       = pop_req && !status.empty;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
    if (do_pop) begin
      pop_data <= mem[rd_ptr];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/ps2_scan_code_key_tracker_unit.sv */
// PS/2 scan code key tracker: prefix decoding, pressed-key map and key FIFO.
// A request goes through the second stage registers and then the output register.
// Throughput: one request per cycle while the output is not stalled; the map row
// read-modify-write overlaps with the next read through a forwarding register.
// Reset clears the prefix flags, FIFO pointers, row valid bits and both
// pipeline valids; no clearing pass is needed.
module ps2_scan_code_key_tracker_unit #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] scan_byte,
  input  logic [7:0] query_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       key_done,
  output logic [7:0] popped_char,
  output logic       is_pressed
);
  import ps2kt_pkg::*;

  // Pressed map memory and its per-row valid bits.
  logic [ROW_WIDTH-1:0]  map_mem [MAP_ROWS];
  logic [MAP_ROWS-1:0]   row_vld;
  logic [ROW_WIDTH-1:0]  map_rd;

  // Prefix flags.
  logic ext_flag;
  logic rel_flag;

  // Request stage signals.
  logic                  in_accept;
  logic                  advance;
  logic                  is_scan;
  logic                  is_prefix;
  logic                  scan_done;
  logic [7:0]            scan_char;
  logic [7:0]            map_addr;

  // Second stage registers.
  logic                  s1_valid;
  logic                  s1_done;
  logic                  s1_press;
  logic                  s1_query;
  logic                  s1_pop_hit;
  logic [ROW_ADDR_W-1:0] s1_row;
  logic [BIT_ADDR_W-1:0] s1_bit;

  // Forwarding of the last row written.
  logic                  fwd_vld;
  logic [ROW_ADDR_W-1:0] fwd_row;
  logic [ROW_WIDTH-1:0]  fwd_data;

  logic [ROW_WIDTH-1:0]  row_old;
  logic [ROW_WIDTH-1:0]  row_new;
  logic [ROW_WIDTH-1:0]  bit_mask;

  // FIFO interface.
  logic                  fifo_push;
  logic                  fifo_pop;
  logic [7:0]            fifo_data;
  fifo_status_t          fifo_stat;

  // Handshake: the second stage moves on whenever the output register frees up.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Decode of the incoming request.
  assign is_scan   = (op == OP_SCAN);
  assign is_prefix = (scan_byte == SCAN_RELEASE) || (scan_byte == SCAN_EXTENDED);
  assign scan_done = is_scan && !is_prefix;
  assign scan_char = char_lookup(scan_byte, ext_flag);
  assign map_addr  = is_scan ? scan_char : query_char;
  assign fifo_push = in_accept && scan_done && !rel_flag;
  assign fifo_pop  = in_accept && (op == OP_POP);

  ps2kt_key_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_req (fifo_push),
    .push_data(scan_char),
    .pop_req  (fifo_pop),
    .pop_data (fifo_data),
    .status   (fifo_stat)
  );

  // Prefix flag register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_flag <= 1'b0;
      rel_flag <= 1'b0;
    end else if (in_accept && is_scan) begin
      if (scan_byte == SCAN_RELEASE) begin
        rel_flag <= 1'b1;
      end else if (scan_byte == SCAN_EXTENDED) begin
        ext_flag <= 1'b1;
      end else begin
        ext_flag <= 1'b0;
        rel_flag <= 1'b0;
      end
    end
  end

  // Second stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Second stage payload and the map row read.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_done    <= scan_done;
      s1_press   <= !rel_flag;
      s1_query   <= (op == OP_QUERY);
      s1_pop_hit <= (op == OP_POP) && !fifo_stat.empty;
      s1_row     <= map_addr[7:BIT_ADDR_W];
      s1_bit     <= map_addr[BIT_ADDR_W-1:0];
      map_rd     <= map_mem[map_addr[7:BIT_ADDR_W]];
    end
  end

  // Current row contents: a write at the read edge wins, an unwritten row reads zero.
  always_comb begin
    if (fwd_vld && (fwd_row == s1_row)) begin
      row_old = fwd_data;
    end else if (row_vld[s1_row]) begin
      row_old = map_rd;
    end else begin
      row_old = '0;
    end
    bit_mask = ROW_WIDTH'(1) << s1_bit;
    row_new  = s1_press ? (row_old | bit_mask) : (row_old & ~bit_mask);
  end

  // Map write-back when a completed key code leaves the second stage.
  always_ff @(posedge clk) begin
    if (advance && s1_done) begin
      map_mem[s1_row] <= row_new;
      fwd_row         <= s1_row;
      fwd_data        <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      fwd_vld <= 1'b0;
    end else if (advance && s1_done) begin
      row_vld[s1_row] <= 1'b1;
      fwd_vld         <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_done    <= s1_done;
      popped_char <= s1_pop_hit ? fifo_data : 8'd0;
      is_pressed  <= s1_query && row_old[s1_bit];
    end
  end

endmodule

/* test/tb_ps2_scan_code_key_tracker_unit.sv */
// Self-checking testbench for the PS/2 scan code key tracker unit.
// Holds a scoreboard class that predicts every result, plus plain driver tasks.
// Depends on rtl/ps2kt_pkg.sv, rtl/ps2kt_key_fifo.sv and rtl/ps2_scan_code_key_tracker_unit.sv.
`timescale 1ns / 1ps

module tb_ps2_scan_code_key_tracker_unit;
  import ps2kt_pkg::*;

  localparam int KEY_QUEUE_DEPTH = 8;
  localparam int TOTAL_REQUESTS = 675;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic       done;
    logic [7:0] popped;
    logic       pressed;
  } key_result_t;

  // Tracks prefix flags, the pressed-key bitmap and the typed-key queue, and
  // compares each result of the block against the oldest prediction.
  class key_state_tracker;
    logic [7:0]  key_char [0:93];
    bit [255:0]  held_keys;
    logic [7:0]  typed_keys[$];
    key_result_t pending_results[$];
    bit          ext_flag;
    bit          rel_flag;
    int          errors;
    int          checked;
    int          key_downs;
    int          key_ups;
    int          drops;
    int          empty_pops;

    function new();
      foreach (key_char[i]) key_char[i] = CHAR_NEWLINE;
      key_char[14] = 8'h60;
      key_char[21] = "Q"; key_char[22] = "1"; key_char[26] = "Z"; key_char[27] = "S";
      key_char[28] = "A"; key_char[29] = "W"; key_char[30] = "2"; key_char[33] = "C";
      key_char[34] = "X"; key_char[35] = "D"; key_char[36] = "E"; key_char[37] = "4";
      key_char[38] = "3"; key_char[41] = " "; key_char[42] = "V"; key_char[43] = "F";
      key_char[44] = "T"; key_char[45] = "R"; key_char[46] = "5"; key_char[49] = "N";
      key_char[50] = "B"; key_char[51] = "H"; key_char[52] = "G"; key_char[53] = "Y";
      key_char[54] = "6"; key_char[58] = "M"; key_char[59] = "J"; key_char[60] = "U";
      key_char[61] = "7"; key_char[62] = "8"; key_char[65] = ","; key_char[66] = "K";
      key_char[67] = "I"; key_char[68] = "O"; key_char[69] = "0"; key_char[70] = "9";
      key_char[73] = "."; key_char[74] = "/"; key_char[75] = "L"; key_char[76] = ";";
      key_char[77] = "P"; key_char[78] = "-"; key_char[82] = "'"; key_char[84] = "[";
      key_char[85] = "="; key_char[91] = "]"; key_char[93] = "\\";
      held_keys = '0;
      ext_flag = 1'b0;
      rel_flag = 1'b0;
      errors = 0;
      checked = 0;
      key_downs = 0;
      key_ups = 0;
      drops = 0;
      empty_pops = 0;
    endfunction

    // Applies one accepted request to the tracked state and queues its result.
    function void note_request(logic [1:0] o, logic [7:0] sb, logic [7:0] qc);
      key_result_t r;
      logic [7:0]  c;
      r = '0;
      if (o == OP_SCAN) begin
        if (sb == SCAN_RELEASE) begin
          rel_flag = 1'b1;
        end else if (sb == SCAN_EXTENDED) begin
          ext_flag = 1'b1;
        end else begin
          if (!ext_flag && sb < TABLE_SIZE) c = key_char[sb];
          else c = CHAR_ENTER;
          if (rel_flag) begin
            held_keys[c] = 1'b0;
            key_ups++;
          end else begin
            held_keys[c] = 1'b1;
            key_downs++;
            if (typed_keys.size() < KEY_QUEUE_DEPTH) typed_keys.push_back(c);
            else drops++;
          end
          ext_flag = 1'b0;
          rel_flag = 1'b0;
          r.done = 1'b1;
        end
      end else if (o == OP_POP) begin
        if (typed_keys.size() > 0) r.popped = typed_keys.pop_front();
        else empty_pops++;
      end else if (o == OP_QUERY) begin
        r.pressed = held_keys[qc];
      end
      pending_results.push_back(r);
    endfunction

    // Compares one accepted result against the oldest prediction.
    function void check_result(logic kd, logic [7:0] pc, logic ip);
      key_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting: key_done=%0b popped_char=%h is_pressed=%0b",
                 $time, kd, pc, ip);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (kd !== want.done) begin
        $display("%0t: key_done expected %0b actual %0b", $time, want.done, kd);
        errors++;
      end
      if (pc !== want.popped) begin
        $display("%0t: popped_char expected %h actual %h", $time, want.popped, pc);
        errors++;
      end
      if (ip !== want.pressed) begin
        $display("%0t: is_pressed expected %0b actual %0b", $time, want.pressed, ip);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] op;
  logic [7:0] scan_byte;
  logic [7:0] query_char;
  logic       out_valid;
  logic       out_stall;
  logic       key_done;
  logic [7:0] popped_char;
  logic       is_pressed;

  key_state_tracker board;
  bit               send_idle;
  bit               recv_idle;
  int               sent;
  logic [7:0]       held_codes[$];

  ps2_scan_code_key_tracker_unit #(
    .FIFO_DEPTH(KEY_QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .scan_byte(scan_byte),
    .query_char(query_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_done(key_done),
    .popped_char(popped_char),
    .is_pressed(is_pressed)
  );

  always #2 clk = ~clk;

  // Presents one request, with an optional idle gap first, and waits until
  // the block takes it.
  task automatic send_request(input logic [1:0] o, input logic [7:0] sb,
                              input logic [7:0] qc);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    scan_byte <= sb;
    query_char <= qc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(o, sb, qc);
    sent++;
  endtask

  task automatic send_scan(input logic [7:0] b);
    send_request(OP_SCAN, b, 8'($urandom_range(0, 255)));
  endtask

  // Mostly codes inside the character table, sometimes any byte at all.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 93));
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiving side: while recv_idle is set, may stall for a random spell before each result.
  // The valid is unknown until the first reset edge, so only a known high counts.
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = recv_idle ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      board.check_result(key_done, popped_char, is_pressed);
    end
  end

  // Main sequence: reset, directed requests, random requests, drain, verdict.
  initial begin
    int         pick;
    int         idx;
    logic [7:0] code;
    board = new();
    sent = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_SCAN;
    scan_byte <= 8'h00;
    query_char <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty pop, table edges, prefixes, unused op, full queue.
    send_request(OP_POP, 8'hFF, 8'hFF);
    send_request(OP_QUERY, 8'h00, 8'h00);
    send_scan(8'h1C);
    send_request(OP_QUERY, 8'h00, "A");
    send_scan(8'h00);
    send_scan(8'h5D);
    send_scan(8'h5E);
    send_scan(8'hFF);
    send_scan(SCAN_EXTENDED);
    send_scan(8'h1C);
    send_request(OP_QUERY, 8'hFF, CHAR_ENTER);
    send_scan(SCAN_RELEASE);
    send_scan(SCAN_EXTENDED);
    send_scan(8'h75);
    send_request(OP_QUERY, 8'h00, CHAR_ENTER);
    send_scan(SCAN_RELEASE);
    send_scan(SCAN_RELEASE);
    send_scan(8'h1C);
    send_request(OP_QUERY, 8'h00, 8'hFF);
    send_request(OP_UNUSED, 8'hFF, 8'hFF);
    send_request(OP_POP, 8'h00, 8'h00);
    // Four more presses overfill the key queue, so the last one is dropped.
    repeat (4) send_scan(8'h15);

    // Random part: mostly well-formed key sequences, with pops, queries and noise.
    while (sent < TOTAL_REQUESTS) begin
      if (sent % 50 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Key press, sometimes with the extended prefix.
        code = pick_code();
        if ($urandom_range(0, 3) == 0) send_scan(SCAN_EXTENDED);
        send_scan(code);
        if (held_codes.size() < 16) held_codes.push_back(code);
      end else if (pick < 55) begin
        // Key release, usually of a key that is down.
        if (held_codes.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, held_codes.size() - 1);
          code = held_codes[idx];
          held_codes.delete(idx);
        end else begin
          code = pick_code();
        end
        case ($urandom_range(0, 3))
          0: begin
            send_scan(SCAN_EXTENDED);
            send_scan(SCAN_RELEASE);
          end
          1: begin
            send_scan(SCAN_RELEASE);
            send_scan(SCAN_EXTENDED);
          end
          default: begin
            send_scan(SCAN_RELEASE);
          end
        endcase
        send_scan(code);
      end else if (pick < 75) begin
        send_request(OP_POP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // Query, half the time a character that the table can produce.
        if ($urandom_range(0, 1) == 0) code = board.key_char[$urandom_range(0, 93)];
        else code = 8'($urandom_range(0, 255));
        send_request(OP_QUERY, 8'($urandom_range(0, 255)), code);
      end else begin
        send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then watch for stray ones.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d key presses, %0d key releases,",
             sent, board.checked, board.key_downs, board.key_ups);
    $display("%0d presses dropped on a full queue, %0d pops from an empty queue.",
             board.drops, board.empty_pops);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
